[rtl/bounded_sequential_list_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded sequential list unit
// Shared property wrappers: implication in the same cycle and in the next.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENTIAL_LIST_UNIT_ASSERT_SVH
`define BOUNDED_SEQUENTIAL_LIST_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BSLU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bslu: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define BSLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bslu: next-cycle check failed");

`endif

[rtl/bslu_pkg.sv]
// ----------------------------------------------------------------------------
// bslu_pkg
// Request codes, status codes and field widths of the sequential list unit.
// ----------------------------------------------------------------------------
package bslu_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] REQ_GET    = 3'd0;
  localparam logic [KIND_W-1:0] REQ_LOCATE = 3'd1;
  localparam logic [KIND_W-1:0] REQ_INSERT = 3'd2;
  localparam logic [KIND_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] REQ_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage

[rtl/bslu_req_if.sv]
// ----------------------------------------------------------------------------
// bslu_req_if
// Request channel: valid/ready handshake with kind, position and value.
// ----------------------------------------------------------------------------
interface bslu_req_if;
  import bslu_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   req_type;
  logic [POS_W-1:0]    position;
  word_t               value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

[rtl/bslu_res_if.sv]
// ----------------------------------------------------------------------------
// bslu_res_if
// Result channel: valid/ready handshake with status, data and list length.
// ----------------------------------------------------------------------------
interface bslu_res_if;
  import bslu_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  word_t               data;
  logic [POS_W-1:0]    found_position;
  logic [POS_W-1:0]    count;
  logic                is_empty;
  logic                last;

  modport source (output valid, output status, output data, output found_position,
                  output count, output is_empty, output last, input ready);
  modport sink   (input valid, input status, input data, input found_position,
                  input count, input is_empty, input last, output ready);
endinterface

[rtl/bounded_sequential_list_unit.sv]
// ----------------------------------------------------------------------------
// bounded_sequential_list_unit
// Ordered list of up to DEPTH signed words held in one synchronous RAM.
// Error, clear and unknown requests go straight to the result stage; get, insert,
// delete and locate walk the RAM first, one RAM access a cycle unless stalled.
// One request at a time; a walk covers up to DEPTH entries.
// Locate results leave as matches are found and stall the walk on back-pressure.
// Reset empties the list at once (length to zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
`include "bounded_sequential_list_unit_assert.svh"

module bounded_sequential_list_unit #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  bslu_req_if.sink   req,
  bslu_res_if.source res
);
  import bslu_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  // one spare bit so that length + 1 never wraps
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state;
  logic [KIND_W-1:0]   kind;
  logic [LW-1:0]       len;
  logic [AW-1:0]       ptr;
  logic [LW-1:0]       rem;
  logic [AW-1:0]       lo;
  word_t               val;
  logic                rd_valid;
  logic [AW-1:0]       rd_idx;
  word_t               rd_data;
  logic                pend_valid;
  logic [POS_W-1:0]    pend_pos;
  logic [STATUS_W-1:0] res_status;
  word_t               res_data;
  logic [POS_W-1:0]    res_fpos;

  word_t               mem [DEPTH];

  logic [CW-1:0]       pos_c;
  logic [CW-1:0]       len_c;
  logic                pos_in_list;
  logic                pos_ins_ok;
  logic                out_free;
  logic                is_loc;
  logic                is_ins;
  logic                is_del;
  logic                match;
  logic                stall;
  logic                issue;
  logic                walk_fin;
  logic                mid_load;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  word_t               wr_data;
  logic [POS_W-1:0]    fpos_now;

  assign req.ready   = (state == S_IDLE);
  assign pos_c       = CW'(req.position);
  assign len_c       = CW'(len);
  assign pos_in_list = (pos_c != '0) && (pos_c <= len_c);
  assign pos_ins_ok  = (pos_c != '0) && (pos_c <= len_c + CW'(1));

  assign out_free = !res.valid || res.ready;
  assign is_loc   = (kind == REQ_LOCATE);
  assign is_ins   = (kind == REQ_INSERT);
  assign is_del   = (kind == REQ_DELETE);
  assign match    = (rd_data == val);
  assign fpos_now = POS_W'(LW'(rd_idx) + LW'(1));

  // a new match must push the held one out; hold the walk when the output is busy
  assign stall    = (state == S_WALK) && rd_valid && is_loc && match && pend_valid
                    && !out_free;
  assign mid_load = (state == S_WALK) && rd_valid && is_loc && match && pend_valid
                    && out_free;
  assign issue    = (state == S_WALK) && (rem != '0) && !stall;
  assign walk_fin = (state == S_WALK) && (rem == '0) && !rd_valid;

  // reads and writes of one walk never touch the same entry in the same cycle
  assign wr_en   = (rd_valid && !stall && (is_ins || is_del) && (state == S_WALK))
                   || (walk_fin && is_ins);
  assign wr_addr = walk_fin ? lo : (is_ins ? rd_idx + AW'(1) : rd_idx - AW'(1));
  assign wr_data = walk_fin ? val : rd_data;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[ptr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind       <= req.req_type;
            val        <= req.value;
            lo         <= AW'(req.position - POS_W'(1));
            pend_valid <= 1'b0;
            res_status <= ST_OK;
            res_data   <= '0;
            res_fpos   <= '0;
            rd_valid   <= 1'b0;
            priority if (req.req_type == REQ_GET) begin
              if (pos_in_list) begin
                rem   <= LW'(1);
                ptr   <= AW'(req.position - POS_W'(1));
                state <= S_WALK;
              end else begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end
            end else if (req.req_type == REQ_LOCATE) begin
              rem   <= len;
              ptr   <= '0;
              state <= S_WALK;
            end else if (req.req_type == REQ_INSERT) begin
              if (!pos_ins_ok) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else if (len == LW'(DEPTH)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                rem   <= len - LW'(req.position) + LW'(1);
                ptr   <= AW'(len - LW'(1));
                state <= S_WALK;
              end
            end else if (req.req_type == REQ_DELETE) begin
              if (pos_in_list) begin
                rem   <= len - LW'(req.position);
                ptr   <= AW'(req.position);
                state <= S_WALK;
              end else begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end
            end else if (req.req_type == REQ_CLEAR) begin
              len   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_DONE;
            end
          end
        end

        S_WALK: begin
          if (issue) begin
            ptr <= is_ins ? ptr - AW'(1) : ptr + AW'(1);
            rem <= rem - LW'(1);
          end
          if (!stall) begin
            rd_valid <= issue;
            rd_idx   <= ptr;
          end
          if (rd_valid && !stall) begin
            if (kind == REQ_GET) begin
              res_data <= rd_data;
            end
            if (is_loc && match) begin
              pend_valid <= 1'b1;
              pend_pos   <= fpos_now;
            end
          end
          if (mid_load) begin
            res.valid          <= 1'b1;
            res.status         <= ST_OK;
            res.data           <= '0;
            res.found_position <= pend_pos;
            res.count          <= POS_W'(len);
            res.is_empty       <= (len == '0);
            res.last           <= 1'b0;
          end
          if (walk_fin) begin
            if (is_ins) begin
              len <= len + LW'(1);
            end
            if (is_del) begin
              len <= len - LW'(1);
            end
            if (is_loc && pend_valid) begin
              res_fpos <= pend_pos;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            res.valid          <= 1'b1;
            res.status         <= res_status;
            res.data           <= res_data;
            res.found_position <= res_fpos;
            res.count          <= POS_W'(len);
            res.is_empty       <= (len == '0);
            res.last           <= 1'b1;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BSLU_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, len <= LW'(DEPTH))
  `BSLU_ASSERT_IMP(a_rd_in_walk, clk, rst, rd_valid, state == S_WALK)
  `BSLU_ASSERT_IMP(a_stall_locate, clk, rst, stall, is_loc && pend_valid)
  `BSLU_ASSERT_NEXT(a_ins_grows, clk, rst, walk_fin && is_ins, len == $past(len) + LW'(1))
  `BSLU_ASSERT_IMP(a_no_req_busy, clk, rst, state != S_IDLE, !req.ready)

endmodule

[tb/bslu_list_checker.sv]
// ----------------------------------------------------------------------------
// bslu_list_checker
// Watches the request and result channels of the sequential list unit. Keeps
// its own copy of the list, works out the results of every accepted request
// and compares each accepted result, field by field, against the oldest one.
// ----------------------------------------------------------------------------
module bslu_list_checker #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  bslu_req_if  req,
  bslu_res_if  res,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import bslu_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    word_t               data;
    logic [POS_W-1:0]    found_position;
    logic [POS_W-1:0]    count;
    logic                is_empty;
    logic                last;
  } list_result_t;

  word_t        list_words [DEPTH];
  int           list_length = 0;
  list_result_t expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // count and empty flag always describe the list after the request
  function automatic list_result_t make_result(input logic [STATUS_W-1:0] status,
                                               input word_t data,
                                               input int found_pos,
                                               input logic last_flag);
    list_result_t r;
    r.status         = status;
    r.data           = data;
    r.found_position = POS_W'(found_pos);
    r.count          = POS_W'(list_length);
    r.is_empty       = (list_length == 0);
    r.last           = last_flag;
    return r;
  endfunction

  task automatic predict_request(input logic [KIND_W-1:0] kind,
                                 input logic [POS_W-1:0] pos,
                                 input word_t val);
    int           p;
    int           hits;
    list_result_t held;
    p = int'(pos);
    case (kind)
      REQ_GET: begin
        if (p < 1 || p > list_length)
          expected_results.push_back(make_result(ST_RANGE, '0, 0, 1'b1));
        else
          expected_results.push_back(make_result(ST_OK, list_words[p-1], 0, 1'b1));
      end
      REQ_LOCATE: begin
        hits = 0;
        // hold each match back until the next one shows it was not the final one
        for (int j = 0; j < list_length; j++) begin
          if (list_words[j] == val) begin
            if (hits > 0) expected_results.push_back(held);
            held = make_result(ST_OK, '0, j + 1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          expected_results.push_back(make_result(ST_OK, '0, 0, 1'b1));
        end else begin
          held.last = 1'b1;
          expected_results.push_back(held);
        end
      end
      REQ_INSERT: begin
        if (p < 1 || p > list_length + 1) begin
          expected_results.push_back(make_result(ST_RANGE, '0, 0, 1'b1));
        end else if (list_length >= DEPTH) begin
          expected_results.push_back(make_result(ST_FULL, '0, 0, 1'b1));
        end else begin
          for (int j = list_length; j > p - 1; j--) list_words[j] = list_words[j-1];
          list_words[p-1] = val;
          list_length++;
          expected_results.push_back(make_result(ST_OK, '0, 0, 1'b1));
        end
      end
      REQ_DELETE: begin
        if (p < 1 || p > list_length) begin
          expected_results.push_back(make_result(ST_RANGE, '0, 0, 1'b1));
        end else begin
          for (int j = p; j < list_length; j++) list_words[j-1] = list_words[j];
          list_length--;
          expected_results.push_back(make_result(ST_OK, '0, 0, 1'b1));
        end
      end
      REQ_CLEAR: begin
        list_length = 0;
        expected_results.push_back(make_result(ST_OK, '0, 0, 1'b1));
      end
      default: begin
        expected_results.push_back(make_result(ST_OK, '0, 0, 1'b1));
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    list_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected, expected none, actual status %0d count %0d",
               $time, res.status, res.count);
      return;
    end
    want = expected_results.pop_front();
    compare_field("status",         want.status,         res.status);
    compare_field("data",           want.data,           res.data);
    compare_field("found_position", want.found_position, res.found_position);
    compare_field("count",          want.count,          res.count);
    compare_field("is_empty",       want.is_empty,       res.is_empty);
    compare_field("last",           want.last,           res.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_length = 0;
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) predict_request(req.req_type, req.position, req.value);
      if (res.valid && res.ready) check_result();
    end
    outstanding <= expected_results.size();
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the sequential list unit with random gaps and random
// result back-pressure: a directed opening on the error and boundary cases,
// then list fills to capacity mixed with random requests. The checker beside
// the unit does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bslu_pkg::*;

  localparam int LIST_DEPTH         = 64;
  localparam int RANDOM_ITEMS       = 210;
  localparam int WATCHDOG_LIMIT     = 5000;
  localparam int DRAIN_CYCLES       = 100;
  localparam int LONG_HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER_RESULTS = 150;

  // request kinds the unit does not define
  localparam logic [KIND_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  localparam word_t WORD_MIN = 32'h8000_0000;
  localparam word_t WORD_MAX = 32'h7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int mismatches;
  int outstanding;
  int results_seen = 0;
  int idle_cycles  = 0;
  int shadow_len   = 0;
  int sent_items   = 0;

  bslu_req_if req_ch ();
  bslu_res_if res_ch ();

  bounded_sequential_list_unit #(.DEPTH(LIST_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  bslu_list_checker #(.DEPTH(LIST_DEPTH)) list_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) results_seen <= results_seen + 1;
  end

  // end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic word_t pick_value(input int pool_pct);
    if ($urandom_range(99) < pool_pct) begin
      case ($urandom_range(5))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return '0;
        3:       return '1;
        4:       return 32'h0000_5a5a;
        default: return 32'h1234_0001;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input logic [KIND_W-1:0] kind);
    int limit_pos;
    if ($urandom_range(99) < 8) return POS_W'($urandom_range(127));
    limit_pos = (kind == REQ_INSERT) ? shadow_len + 1 : shadow_len;
    if (limit_pos == 0) return POS_W'(1);
    return POS_W'($urandom_range(limit_pos, 1));
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input word_t val);
    int gap;
    // every fourth stretch of thirty requests goes back to back
    gap = (((sent_items / 30) % 4) == 1) ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    sent_items++;
    case (kind)
      REQ_INSERT: if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < LIST_DEPTH) shadow_len++;
      REQ_DELETE: if (pos >= 1 && pos <= shadow_len) shadow_len--;
      REQ_CLEAR:  shadow_len = 0;
      default:    ;
    endcase
  endtask

  task automatic send_random();
    int                r;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(99);
    if (r < 24)      kind = REQ_INSERT;
    else if (r < 42) kind = REQ_DELETE;
    else if (r < 60) kind = REQ_GET;
    else if (r < 82) kind = REQ_LOCATE;
    else if (r < 85) kind = REQ_CLEAR;
    else if (r < 90) kind = KIND_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
    else             kind = KIND_W'($urandom_range(REQ_UNUSED_LAST));
    send_request(kind, pick_position(kind), pick_value(70));
  endtask

  // result side: short random stalls, quiet stretches, one long hold-off
  initial begin : result_sink
    int stall_left;
    int rx_cycle;
    int r;
    bit long_hold_done;
    stall_left     = 0;
    rx_cycle       = 0;
    long_hold_done = 0;
    res_ch.ready   = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      rx_cycle++;
      if (!long_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
        stall_left     = LONG_HOLD_CYCLES;
        long_hold_done = 1;
      end else if (stall_left == 0 && ((rx_cycle / 200) % 3) != 1) begin
        r = $urandom_range(99);
        if (r < 70)      stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(3, 1);
        else if (r < 98) stall_left = $urandom_range(12, 4);
        else             stall_left = $urandom_range(60, 20);
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin : request_source
    bit filling;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_GET;
    req_ch.position = '0;
    req_ch.value    = '0;
    while (rst) @(negedge clk);

    // empty list: every position is out of range, nothing to find
    send_request(REQ_GET, 1, '0);
    send_request(REQ_DELETE, 1, '0);
    send_request(REQ_LOCATE, 0, WORD_MIN);
    send_request(REQ_INSERT, 0, WORD_MAX);
    send_request(REQ_INSERT, 2, WORD_MAX);
    // build MIN MIN MAX -1 through front, end and middle inserts
    send_request(REQ_INSERT, 1, WORD_MAX);
    send_request(REQ_INSERT, 1, WORD_MIN);
    send_request(REQ_INSERT, 3, '1);
    send_request(REQ_INSERT, 2, WORD_MIN);
    send_request(REQ_GET, 1, '0);
    send_request(REQ_GET, 4, '0);
    send_request(REQ_GET, 5, '0);
    send_request(REQ_GET, 0, '0);
    send_request(REQ_GET, 127, '1);
    send_request(REQ_LOCATE, 0, WORD_MIN);
    send_request(REQ_LOCATE, 127, 32'h0000_0001);
    send_request(REQ_DELETE, 4, '0);
    send_request(REQ_DELETE, 5, '0);
    send_request(REQ_DELETE, 1, '0);
    send_request(REQ_DELETE, 0, '0);
    send_request(REQ_UNUSED_FIRST, 127, WORD_MAX);
    send_request(KIND_W'(REQ_UNUSED_FIRST + 1), 64, WORD_MIN);
    send_request(REQ_UNUSED_LAST, 65, '1);
    send_request(REQ_CLEAR, 0, '0);
    send_request(REQ_GET, 1, '0);

    filling = 1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2 + 15) filling = 1;
      if (filling && shadow_len == LIST_DEPTH) begin
        // full list: a valid insert position reports full, a bad one reports range
        send_request(REQ_INSERT, POS_W'($urandom_range(LIST_DEPTH + 1, 1)), pick_value(50));
        send_request(REQ_INSERT, POS_W'(LIST_DEPTH + 2), pick_value(50));
        send_request(REQ_LOCATE, '0, pick_value(100));
        send_request(REQ_GET, POS_W'(LIST_DEPTH), '0);
        filling = 0;
      end else if (filling) begin
        if ($urandom_range(99) < 85)
          send_request(REQ_INSERT, pick_position(REQ_INSERT), pick_value(70));
        else
          send_random();
      end else begin
        send_random();
      end
    end
    req_ch.valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
